>>> hdl/lppd_pkg.sv
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants for the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

    localparam int HEADER_BYTES_DEF = 20;
    localparam int IDX_W            = 5;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 16;
    localparam int CNT_W            = 16;
    localparam int IN_DATA_W        = 8;
    localparam int OUT_DATA_W       = 40;
    localparam int OUT_USER_W       = 3;

    // two big-endian extension bytes; the first is held, the second completes
    localparam logic [IDX_W-1:0]  EXT_LAST_IDX = IDX_W'(1);
    localparam logic [BYTE_W-1:0] LEN_ESCAPE   = 8'hFF;

    // m_axis_tuser bit positions
    localparam int USR_IN_HEADER    = 0;
    localparam int USR_PACKET_START = 1;
    localparam int USR_LENGTH_VALID = 2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_EXT     = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

endpackage

>>> hdl/length_prefixed_packet_deframer.sv
// An accepted input byte is registered and appears as its tagged output transaction in the next cycle.
// Throughput: 1 byte per cycle unless m_axis_tready stalls a full output register;
// the single output register is refilled in the same cycle it is drained, so s_axis_tready follows m_axis_tready.
// Reset: synchronous active-low i_rst_n returns the parser to the first header
// byte, clears the chunk counter and empties the output register.
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Splits a byte stream into header/payload-tagged packets using a length byte
// in the header, with a 16-bit extended length when that byte is 0xFF.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer #(
    parameter int HEADER_BYTES = lppd_pkg::HEADER_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lppd_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic                             s_axis_tlast,   // chunk_last
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] out_byte, [23:8] payload_length, [39:24] chunks_seen
    output logic [lppd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] in_header, [1] packet_start, [2] length_valid
    output logic [lppd_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output logic                             m_axis_tlast    // packet_end
);

    localparam logic [lppd_pkg::IDX_W-1:0] HDR_LAST_IDX = lppd_pkg::IDX_W'(HEADER_BYTES - 1);

    lppd_pkg::t_phase                 r_phase, n_phase;
    logic [lppd_pkg::IDX_W-1:0]       r_hdr_idx, n_hdr_idx;
    logic [lppd_pkg::BYTE_W-1:0]      r_len_high, n_len_high;
    logic [lppd_pkg::LEN_W-1:0]       r_pay_left, n_pay_left;
    logic [lppd_pkg::CNT_W-1:0]       r_chunk_cnt, n_chunk_cnt;

    logic                             r_out_valid;
    logic [lppd_pkg::OUT_DATA_W-1:0]  r_out_data;
    logic [lppd_pkg::OUT_USER_W-1:0]  r_out_user;
    logic                             r_out_last;

    logic                             accept;
    logic [lppd_pkg::BYTE_W-1:0]      in_byte;
    logic [lppd_pkg::LEN_W-1:0]       pay_dec;
    logic [lppd_pkg::LEN_W-1:0]       ext_len;

    logic                             have_len;
    logic [lppd_pkg::LEN_W-1:0]       dec_len;
    logic                             hdr_flag, start_flag, end_flag;

    assign in_byte       = s_axis_tdata[lppd_pkg::BYTE_W-1:0];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pay_dec       = r_pay_left - lppd_pkg::LEN_W'(1);
    assign ext_len       = {r_len_high, in_byte};
    assign n_chunk_cnt   = s_axis_tlast ? r_chunk_cnt + lppd_pkg::CNT_W'(1) : r_chunk_cnt;

    // output decode
    always_comb begin
        hdr_flag   = 1'b1;
        start_flag = 1'b0;
        end_flag   = 1'b0;
        have_len   = 1'b0;
        dec_len    = '0;
        case (r_phase)
            lppd_pkg::PH_PAYLOAD: begin
                hdr_flag = 1'b0;
                end_flag = (pay_dec == '0);
            end
            lppd_pkg::PH_EXT: begin
                if (r_hdr_idx >= lppd_pkg::EXT_LAST_IDX) begin
                    have_len = 1'b1;
                    dec_len  = ext_len;
                end
            end
            default: begin
                start_flag = (r_hdr_idx == '0);
                if (r_hdr_idx >= HDR_LAST_IDX && in_byte != lppd_pkg::LEN_ESCAPE) begin
                    have_len = 1'b1;
                    dec_len  = {{(lppd_pkg::LEN_W-lppd_pkg::BYTE_W){1'b0}}, in_byte};
                end
            end
        endcase
        if (have_len && dec_len == '0) begin
            end_flag = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_len_high = r_len_high;
        n_pay_left = r_pay_left;
        case (r_phase)
            lppd_pkg::PH_PAYLOAD: begin
                n_pay_left = pay_dec;
                if (pay_dec == '0) begin
                    n_phase   = lppd_pkg::PH_HEADER;
                    n_hdr_idx = '0;
                end
            end
            lppd_pkg::PH_EXT: begin
                if (r_hdr_idx < lppd_pkg::EXT_LAST_IDX) begin
                    n_len_high = in_byte;
                    n_hdr_idx  = r_hdr_idx + lppd_pkg::IDX_W'(1);
                end
            end
            default: begin
                if (r_hdr_idx >= HDR_LAST_IDX) begin
                    if (in_byte == lppd_pkg::LEN_ESCAPE) begin
                        n_phase   = lppd_pkg::PH_EXT;
                        n_hdr_idx = '0;
                    end
                end else begin
                    n_phase   = lppd_pkg::PH_HEADER;
                    n_hdr_idx = r_hdr_idx + lppd_pkg::IDX_W'(1);
                end
            end
        endcase
        if (have_len) begin
            n_hdr_idx  = '0;
            n_pay_left = dec_len;
            n_phase    = (dec_len == '0) ? lppd_pkg::PH_HEADER : lppd_pkg::PH_PAYLOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lppd_pkg::PH_HEADER;
            r_hdr_idx   <= '0;
            r_len_high  <= '0;
            r_pay_left  <= '0;
            r_chunk_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_hdr_idx   <= n_hdr_idx;
                r_len_high  <= n_len_high;
                r_pay_left  <= n_pay_left;
                r_chunk_cnt <= n_chunk_cnt;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {n_chunk_cnt, dec_len, in_byte};
            r_out_user <= {have_len, start_flag, hdr_flag};
            r_out_last <= end_flag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> hdl/lppd_checker.sv
// ----------------------------------------------------------------------------
// lppd_checker
// Port-level checks for the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
module lppd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [lppd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [lppd_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    input logic                             m_axis_tlast
);

    // a stalled output transaction holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // a draining output always frees the input side
    a_ready_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_len_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[lppd_pkg::USR_LENGTH_VALID]
            |-> m_axis_tuser[lppd_pkg::USR_IN_HEADER])
        else $error("length reported on payload byte");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[lppd_pkg::USR_LENGTH_VALID]
            |-> m_axis_tdata[23:8] == '0)
        else $error("length nonzero without length_valid");

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker (.*);
